### src/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// Shared widths, state encoding and shared-unit request/response types for
// the RMS meter.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int SUM_W           = 47;
  localparam int CNT_W           = 17;
  localparam int RMS_W           = 16;
  localparam int S_DATA_W        = 16;
  localparam int M_DATA_W        = 40;
  localparam int MAX_SAMPLES_DEF = 65536;

  // Shared subtract/compare unit and iteration bookkeeping
  localparam int UNIT_W     = 20;
  localparam int REM_W      = 18;
  localparam int SQ_W       = 32;
  localparam int MEAN_W     = 31;
  localparam int ITER_W     = 6;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = SQ_W / 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] diff;
    logic              ge;
  } unit_rsp_t;

endpackage

### src/rms_sub_unit.sv
// ----------------------------------------------------------------------------
// rms_sub_unit
// Shared trial subtractor: a - b with a greater-or-equal flag. Serves both
// the restoring divider and the digit-by-digit square root.
// ----------------------------------------------------------------------------
module rms_sub_unit
  import rms_pkg::*;
(
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic [UNIT_W:0] wide;

  assign wide     = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff = wide[UNIT_W-1:0];
  assign rsp.ge   = ~wide[UNIT_W];

endmodule

### src/block_rms_meter.sv
// ----------------------------------------------------------------------------
// block_rms_meter
// Block RMS meter: sums squared samples, then on the last sample of a block
// emits floor(sqrt(floor(sum / count))), the count and an overflow flag.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | tdata bits (low first)                | side bits
//  --------+-----+---------------------------------------+-------------------
//  s_*     | in  | [15:0] sample (signed)                | tlast = last_sample
//  m_*     | out | [15:0] rms_value, [32:16] sample_count | tuser = overflow
//          |     | [39:33] zero                          |
//
//  Flow: a word without tlast is taken every cycle while the sequencer
//  is idle. A word with tlast starts the result pass: restoring division
//  (one quotient bit per cycle), then square root (one root bit per
//  cycle), both on one shared subtractor, then a hold state that loads the
//  output register: s_tready is low after such a word until that load.
//  Reset: rst (synchronous, active high) clears the sum, count, overflow
//  flag, the sequencer and m_tvalid.
//  Stalls: a result waits in the output register while m_tready is low;
//  new words are taken meanwhile, and the sequencer holds only when a
//  second result is ready before the first has been taken.
//
module block_rms_meter
  import rms_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] sample
  input  logic                s_tlast,   // last_sample
  // Result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [15:0] rms_value, [32:16] sample_count
  output logic                m_tuser    // overflow
);

  // --------------------------------------------------------------------------
  // Accumulator
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]      square_sum;
  logic [CNT_W-1:0]      count_so_far;
  logic                  dropped_flag;

  logic                  accept;
  logic [SAMPLE_W-1:0]   mag;
  logic [2*SAMPLE_W-1:0] sq;
  logic                  can_add;
  logic [SUM_W-1:0]      sum_next;
  logic [CNT_W-1:0]      count_next;
  logic                  dropped_next;

  assign accept  = s_tvalid && s_tready;
  // Two's complement magnitude; the most negative value maps to 0x8000
  assign mag     = s_tdata[SAMPLE_W-1] ? (~s_tdata + SAMPLE_W'(1)) : s_tdata;
  assign sq      = mag * mag;
  assign can_add = count_so_far < CNT_W'(MAX_SAMPLES);

  always_comb begin
    if (can_add) begin
      sum_next     = square_sum + SUM_W'(sq);
      count_next   = count_so_far + CNT_W'(1);
      dropped_next = dropped_flag;
    end else begin
      // Block too long: drop the word, flag it
      sum_next     = square_sum;
      count_next   = count_so_far;
      dropped_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      count_so_far <= '0;
      dropped_flag <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        // Block ends: totals move to the work registers, start fresh
        square_sum   <= '0;
        count_so_far <= '0;
        dropped_flag <= 1'b0;
      end else begin
        square_sum   <= sum_next;
        count_so_far <= count_next;
        dropped_flag <= dropped_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t            state;
  state_t            state_next;
  logic [ITER_W-1:0] iter;
  logic              div_done;
  logic              sqrt_done;
  logic              out_free;

  assign div_done  = (iter == ITER_W'(DIV_STEPS - 1));
  assign sqrt_done = (iter == ITER_W'(SQRT_STEPS - 1));
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && s_tlast) state_next = ST_DIV;
      ST_DIV:  if (div_done)          state_next = ST_SQRT;
      ST_SQRT: if (sqrt_done)         state_next = ST_HOLD;
      ST_HOLD: if (out_free)          state_next = ST_IDLE;
      default:                        state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Shared subtractor and its operand selection
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]  div_q;      // dividend shifts out the top, quotient in
  logic [REM_W-1:0]  div_rem;
  logic [CNT_W-1:0]  work_cnt;
  logic              work_ovf;
  logic [SQ_W-1:0]   sq_val;
  logic [REM_W-1:0]  sq_rem;
  logic [RMS_W-1:0]  root;

  logic [REM_W-1:0]  div_shift;
  logic [UNIT_W-1:0] sq_shift;
  logic [SUM_W-1:0]  q_next;
  logic [MEAN_W-1:0] mean;

  unit_req_t unit_req;
  unit_rsp_t unit_rsp;

  assign div_shift = {div_rem[CNT_W-1:0], div_q[SUM_W-1]};
  assign sq_shift  = {sq_rem, sq_val[SQ_W-1 -: 2]};
  assign q_next    = {div_q[SUM_W-2:0], unit_rsp.ge};
  // A zero count gives a zero mean
  assign mean      = (work_cnt == '0) ? '0 : q_next[MEAN_W-1:0];

  always_comb begin
    s_tready   = 1'b0;
    unit_req.a = '0;
    unit_req.b = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_DIV: begin
        unit_req.a = UNIT_W'(div_shift);
        unit_req.b = UNIT_W'(work_cnt);
      end
      ST_SQRT: begin
        unit_req.a = sq_shift;
        unit_req.b = UNIT_W'({root, 2'b01});
      end
      ST_HOLD: begin
        s_tready = 1'b0;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  rms_sub_unit u_sub (
    .req (unit_req),
    .rsp (unit_rsp)
  );

  // --------------------------------------------------------------------------
  // Work registers: divide, then square root
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else begin
      unique case (state)
        ST_IDLE: iter <= '0;
        ST_DIV:  iter <= div_done ? '0 : iter + ITER_W'(1);
        ST_SQRT: iter <= iter + ITER_W'(1);
        ST_HOLD: iter <= '0;
        default: iter <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tlast) begin
          // Fold the last word in and latch the block totals
          div_q    <= sum_next;
          div_rem  <= '0;
          work_cnt <= count_next;
          work_ovf <= dropped_next;
        end
      end
      ST_DIV: begin
        div_q   <= q_next;
        div_rem <= unit_rsp.ge ? unit_rsp.diff[REM_W-1:0] : div_shift;
        if (div_done) begin
          sq_val <= SQ_W'(mean);
          sq_rem <= '0;
          root   <= '0;
        end
      end
      ST_SQRT: begin
        sq_val <= {sq_val[SQ_W-3:0], 2'b00};
        if (unit_rsp.ge) begin
          sq_rem <= unit_rsp.diff[REM_W-1:0];
          root   <= {root[RMS_W-2:0], 1'b1};
        end else begin
          sq_rem <= sq_shift[REM_W-1:0];
          root   <= {root[RMS_W-2:0], 1'b0};
        end
      end
      ST_HOLD: begin
        // hold work registers
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic load_out;

  assign load_out = (state == ST_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= M_DATA_W'({work_cnt, root});
      m_tuser <= work_ovf;
    end
  end

endmodule

### src/rms_checker.sv
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks on the RMS meter, bound to every instance of the top.
// ----------------------------------------------------------------------------
module rms_checker
  import rms_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [S_DATA_W-1:0] s_tdata,
  input logic                s_tlast,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Every block counts at least one sample, and padding stays zero
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[32:16] != '0) && (m_tdata[M_DATA_W-1:33] == '0))
    else $error("bad sample_count or padding");

  // The root of a mean of 16-bit squares never exceeds 32768
  a_rms_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:0] <= 16'd32768)
    else $error("rms_value out of range");

  // A block end starts the result pass: input stalls next cycle
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken during result pass");

endmodule

bind block_rms_meter rms_checker u_rms_checker (.*);

### tb/sv/tb_block_rms_meter.sv
// ----------------------------------------------------------------------------
// tb_block_rms_meter
// Self-checking bench for the block RMS meter. A short table of directed
// blocks (sample extremes, full-length and over-length blocks) is followed by
// random blocks, mostly under random source and sink idling. Each result
// word is compared field by field with its typed expectation or with an
// integer sum-of-squares / divide / root predictor kept alongside the stream.
// ----------------------------------------------------------------------------
module tb_block_rms_meter;
  import rms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Expected result word: one per block
  typedef struct packed {
    logic [RMS_W-1:0] rms;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
  } rms_word_t;

  // Directed stimulus row: the sample repeats reps times, the last mark
  // goes on the final repetition only. Rows with known set carry their
  // expected result typed in.
  typedef struct packed {
    bit [SAMPLE_W-1:0] smp;
    bit                lst;
    int                reps;
    bit                known;
    bit [RMS_W-1:0]    rms;
    bit [CNT_W-1:0]    cnt;
    bit                ovf;
  } stim_row_t;

  localparam int NUM_ROWS = 21;

  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    // single-sample blocks at the extremes
    '{16'h0000, 1'b1, 1, 1'b1, 16'd0,     17'd1,     1'b0},
    '{16'h7FFF, 1'b1, 1, 1'b1, 16'd32767, 17'd1,     1'b0},
    '{16'h8000, 1'b1, 1, 1'b1, 16'd32768, 17'd1,     1'b0},
    '{16'hFFFF, 1'b1, 1, 1'b1, 16'd1,     17'd1,     1'b0},
    '{16'h0001, 1'b1, 1, 1'b1, 16'd1,     17'd1,     1'b0},
    // mean truncating to zero
    '{16'h0001, 1'b0, 1, 1'b0, 16'd0,     17'd0,     1'b0},
    '{16'h0000, 1'b1, 1, 1'b0, 16'd0,     17'd0,     1'b0},
    // 3, -4: mean 12
    '{16'h0003, 1'b0, 1, 1'b0, 16'd0,     17'd0,     1'b0},
    '{16'hFFFC, 1'b1, 1, 1'b0, 16'd0,     17'd0,     1'b0},
    // alternating bit patterns
    '{16'h5555, 1'b0, 1, 1'b0, 16'd0,     17'd0,     1'b0},
    '{16'hAAAA, 1'b1, 1, 1'b0, 16'd0,     17'd0,     1'b0},
    '{16'h7FFF, 1'b0, 1, 1'b0, 16'd0,     17'd0,     1'b0},
    '{16'h8000, 1'b0, 1, 1'b0, 16'd0,     17'd0,     1'b0},
    '{16'h0000, 1'b1, 1, 1'b0, 16'd0,     17'd0,     1'b0},
    // full-length block of the largest square: widest sum
    '{16'h8000, 1'b1, 65536, 1'b1, 16'd32768, 17'd65536, 1'b0},
    // block too long, the last sample itself is dropped
    '{16'h0064, 1'b0, 65536, 1'b0, 16'd0,   17'd0,     1'b0},
    '{16'h8000, 1'b1, 1,     1'b1, 16'd100, 17'd65536, 1'b1},
    // block too long by several samples
    '{16'h0007, 1'b0, 65536, 1'b0, 16'd0,   17'd0,     1'b0},
    '{16'h0005, 1'b0, 3,     1'b0, 16'd0,   17'd0,     1'b0},
    '{16'h0009, 1'b1, 1,     1'b1, 16'd7,   17'd65536, 1'b1},
    // overflow flag must be clear again
    '{16'h1234, 1'b1, 1,     1'b0, 16'd0,   17'd0,     1'b0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // [15:0] sample
  logic                s_tlast = 1'b0; // last_sample
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // [15:0] rms_value, [32:16] sample_count
  logic                m_tuser;        // overflow

  // Predictor state
  longint unsigned acc_sum;
  int unsigned     acc_count;
  bit              acc_dropped;

  rms_word_t want_q[$];
  int        errors = 0;

  // Idling controls set by the source; tx_no_idle is read by the source, the others by the sink
  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  bit hold_rx    = 1'b0;

  block_rms_meter #(
    .MAX_SAMPLES(MAX_SAMPLES_DEF)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Fold one accepted sample into the running block. Returns 1 and fills
  // the result word when the sample closes the block.
  function automatic bit fold_sample(input logic [SAMPLE_W-1:0] smp, input bit lst,
                                     output rms_word_t w);
    longint          mag;
    longint unsigned mean;
    longint unsigned root;
    longint unsigned trial;
    int              b;
    mag = $signed(smp);
    if (mag < 0) mag = -mag;
    w = '0;
    // Drop the sample once the block holds the maximum count
    if (acc_count < MAX_SAMPLES_DEF) begin
      acc_sum   = (acc_sum + longint'(mag * mag)) & ((64'd1 << SUM_W) - 1);
      acc_count = acc_count + 1;
    end else begin
      acc_dropped = 1'b1;
    end
    if (!lst) return 1'b0;
    mean = (acc_count != 0) ? acc_sum / acc_count : 0;
    // Build the truncated root one bit at a time, high bit first
    root = 0;
    for (b = RMS_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= mean) root = trial;
    end
    w.rms = root[RMS_W-1:0];
    w.cnt = acc_count[CNT_W-1:0];
    w.ovf = acc_dropped;
    acc_sum     = 0;
    acc_count   = 0;
    acc_dropped = 1'b0;
    return 1'b1;
  endfunction

  // Offer one word and hold it until the block takes it. Idle cycles in
  // front of it carry junk data with tvalid low.
  task automatic send_word(input logic [SAMPLE_W-1:0] smp, input bit lst, input bit gapless);
    int gap;
    gap = (gapless || tx_no_idle) ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= S_DATA_W'($urandom);
      s_tlast  <= 1'($urandom_range(0, 1));
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
  endtask

  // Send a sample and queue the predicted result if it closes a block.
  task automatic offer(input logic [SAMPLE_W-1:0] smp, input bit lst, input bit gapless);
    rms_word_t w;
    send_word(smp, lst, gapless);
    if (fold_sample(smp, lst, w)) want_q.push_back(w);
  endtask

  // Drop tvalid and hold the source until every queued result is out.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
  endtask

  // Source: directed table, then random blocks in phases
  initial begin : tx_side
    rms_word_t             w;
    rms_word_t             typed;
    logic [SAMPLE_W-1:0]   smp;
    int                    r;
    int                    k;
    int                    seg;
    int                    sent;
    int                    len;
    acc_sum     = 0;
    acc_count   = 0;
    acc_dropped = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < NUM_ROWS; r++) begin
      for (k = 0; k < DIR_ROWS[r].reps; k++) begin
        // long rows stream back to back to keep the run short
        send_word(DIR_ROWS[r].smp, DIR_ROWS[r].lst && (k == DIR_ROWS[r].reps - 1),
                  DIR_ROWS[r].reps > 1);
        if (fold_sample(DIR_ROWS[r].smp, DIR_ROWS[r].lst && (k == DIR_ROWS[r].reps - 1), w))
        begin
          if (DIR_ROWS[r].known) begin
            typed.rms = DIR_ROWS[r].rms;
            typed.cnt = DIR_ROWS[r].cnt;
            typed.ovf = DIR_ROWS[r].ovf;
            want_q.push_back(typed);
          end else begin
            want_q.push_back(w);
          end
        end
      end
    end
    wait_drained();

    // Phase 2 runs without idling on either side; phase 4 sends short
    // gapless blocks while the sink holds off, so the block backs up.
    for (seg = 0; seg < 6; seg++) begin
      tx_no_idle = (seg == 2);
      rx_no_idle = (seg == 2);
      if (seg == 4) hold_rx = 1'b1;
      sent = 0;
      while (sent < 125) begin
        if (seg == 4) begin
          len = $urandom_range(1, 3);
        end else begin
          case ($urandom_range(0, 9))
            8:       len = $urandom_range(17, 64);
            9:       len = $urandom_range(65, 200);
            default: len = $urandom_range(1, 16);
          endcase
        end
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 7))
            0:       smp = 16'h8000;
            1:       smp = 16'h7FFF;
            2:       smp = SAMPLE_W'($urandom_range(0, 15));
            3:       smp = 16'h0000 - 16'($urandom_range(0, 15));
            default: smp = SAMPLE_W'($urandom);
          endcase
          offer(smp, k == len - 1, seg == 4);
        end
        sent += len;
      end
      if (seg == 3) wait_drained();
    end

    wait_drained();
    // let any stray word show up before the verdict
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Sink: random back-pressure, with one long hold-off on request
  initial begin : rx_side
    int gap;
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (hold_rx && !held) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (399) @(negedge clk);
        held = 1'b1;
      end
      gap = rx_no_idle ? 0 : $urandom_range(0, 19);
      repeat (gap) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Check every word taken from the result stream against the oldest
  // expectation.
  always @(posedge clk) begin : result_check
    rms_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (want_q.size() == 0) begin
        $error("unexpected result word: rms_value %0d sample_count %0d overflow %0d",
               m_tdata[15:0], m_tdata[32:16], m_tuser);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (m_tdata[15:0] !== w.rms) begin
          $error("rms_value: expected %0d, got %0d", w.rms, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[32:16] !== w.cnt) begin
          $error("sample_count: expected %0d, got %0d", w.cnt, m_tdata[32:16]);
          errors++;
        end
        if (m_tuser !== w.ovf) begin
          $error("overflow: expected %0d, got %0d", w.ovf, m_tuser);
          errors++;
        end
        if (m_tdata[M_DATA_W-1:33] !== '0) begin
          $error("tdata pad: expected 0, got %0h", m_tdata[M_DATA_W-1:33]);
          errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
